// ===== design/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo refresh scheduler package
// Shared constants, operation codes and the timer step result type.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

  // Default configuration of the scheduler.
  localparam int CHANNELS_DEF          = 20;
  localparam int RELEASE_TICKS_DEF     = 100;

  // Field widths fixed by the item format.
  localparam int OP_W       = 2;
  localparam int CHAN_W     = 5;
  localparam int POS_W      = 8;
  localparam int DUR_W      = 16;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 16;

  // A timer at this value is stopped.
  localparam logic [DUR_W-1:0] TIMER_STOPPED = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_TICK         = 2'd0,
    OP_SET_POSITION = 2'd1,
    OP_SET_DURATION = 2'd2,
    OP_UNUSED       = 2'd3
  } srs_op_t;

  // Result of advancing one channel's release timer by one tick.
  typedef struct packed {
    logic [DUR_W-1:0] timer_next;
    logic             release_now;
  } srs_step_t;

endpackage

`default_nettype wire

// ===== design/srs_timer_unit.sv =====
// ----------------------------------------------------------------------------
// Servo refresh scheduler timer unit
// Shared incrementer and compare that advances one release timer per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_timer_unit (
  input  wire logic [srs_pkg::DUR_W-1:0] timer,
  input  wire logic [srs_pkg::DUR_W-1:0] duration,
  output srs_pkg::srs_step_t             step
);

  logic                      running;
  logic [srs_pkg::DUR_W-1:0] incremented;

  always_comb begin
    running     = (timer != srs_pkg::TIMER_STOPPED);
    incremented = timer + srs_pkg::DUR_W'(1);
    step.release_now = running && (incremented > duration);
    if (step.release_now) begin
      step.timer_next = srs_pkg::TIMER_STOPPED;
    end else if (running) begin
      step.timer_next = incremented;
    end else begin
      step.timer_next = timer;
    end
  end

endmodule

`default_nettype wire

// ===== design/servo_refresh_scheduler.sv =====
// ----------------------------------------------------------------------------
// Servo refresh scheduler
// Per-channel release timers with a round-robin refresh of pending channels.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  tuser: operation
//                                            tdata: channel, new_position,
//                                                   new_duration
//  m_*       out        m_tvalid / m_tready  tdata: register_number,
//                                                   position_value
//
// A set-position or set-duration transaction updates the addressed channel
// at once if it is in range; it never produces a result.
// After a tick transaction is taken, s_tready stays low while one shared
// timer unit walks the channels one per cycle, starting just after the last
// served channel, advancing each timer and picking the first pending channel
// on the way. The emit step then loads the result register if a channel was
// picked; if that register still holds an untaken result, the block waits
// there until the downstream side takes it. s_tready is high only while the
// sequencer is idle.
// Reset (rst, synchronous, active high) stops every timer, loads the default
// release duration, zeroes positions and marks every channel pending.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_refresh_scheduler #(
  parameter int CHANNELS              = srs_pkg::CHANNELS_DEF,
  parameter int DEFAULT_RELEASE_TICKS = srs_pkg::RELEASE_TICKS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,

  input  wire logic                         s_tvalid,
  output      logic                         s_tready,
  // [1:0] operation
  input  wire logic [srs_pkg::OP_W-1:0]     s_tuser,
  // [4:0] channel, [12:5] new_position, [28:13] new_duration, [31:29] zero
  input  wire logic [srs_pkg::S_DATA_W-1:0] s_tdata,

  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  // [4:0] register_number, [12:5] position_value, [15:13] zero
  output      logic [srs_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  typedef enum logic [1:0] {
    IDLE_S,
    WALK_S,
    EMIT_S
  } state_t;

  state_t state;

  // Per-channel state, one entry per channel, walked by the sequencer.
  logic [srs_pkg::DUR_W-1:0] timers    [CHANNELS];
  logic [srs_pkg::DUR_W-1:0] durations [CHANNELS];
  logic [srs_pkg::POS_W-1:0] positions [CHANNELS];
  logic [CHANNELS-1:0]       pending;
  logic [IDX_W-1:0]          last_served;

  // Walk control and the channel picked during the walk.
  logic [IDX_W-1:0]          idx;
  logic [CNT_W-1:0]          step_cnt;
  logic                      found;
  logic [IDX_W-1:0]          found_idx;
  logic [srs_pkg::POS_W-1:0] found_pos;

  // Unpacked input fields.
  srs_pkg::srs_op_t            operation;
  logic [srs_pkg::CHAN_W-1:0]  channel;
  logic [srs_pkg::POS_W-1:0]   new_position;
  logic [srs_pkg::DUR_W-1:0]   new_duration;
  logic                        chan_ok;
  logic [IDX_W-1:0]            chan_idx;
  logic                        accept;

  srs_pkg::srs_step_t          step;
  logic                        pend_now;
  logic [srs_pkg::POS_W-1:0]   pos_now;
  logic [IDX_W-1:0]            idx_next;
  logic [IDX_W-1:0]            start_idx;

  assign operation    = srs_pkg::srs_op_t'(s_tuser);
  assign channel      = s_tdata[4:0];
  assign new_position = s_tdata[12:5];
  assign new_duration = s_tdata[28:13];
  assign chan_ok      = ({1'b0, channel} < 6'(CHANNELS));
  assign chan_idx     = channel[IDX_W-1:0];

  assign s_tready = (state == IDLE_S);
  assign accept   = s_tvalid && s_tready;

  // The single timer unit serves whichever channel the walk is on.
  srs_timer_unit u_timer (
    .timer    (timers[idx]),
    .duration (durations[idx]),
    .step     (step)
  );

  // A released channel becomes pending and its position drops to zero.
  assign pend_now  = pending[idx] || step.release_now;
  assign pos_now   = step.release_now ? '0 : positions[idx];
  assign idx_next  = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  assign start_idx = (last_served == LAST_IDX) ? '0 : last_served + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE_S;
      m_tvalid    <= 1'b0;
      pending     <= '1;
      last_served <= '0;
      found       <= 1'b0;
      idx         <= '0;
      step_cnt    <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        timers[c]    <= srs_pkg::TIMER_STOPPED;
        durations[c] <= srs_pkg::DUR_W'(DEFAULT_RELEASE_TICKS);
        positions[c] <= '0;
      end
    end else begin
      // The emit step reloads the result register itself when it fires.
      if (m_tvalid && m_tready && !(state == EMIT_S && found)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE_S: begin
          if (accept) begin
            case (operation)
              srs_pkg::OP_TICK: begin
                state    <= WALK_S;
                idx      <= start_idx;
                step_cnt <= '0;
                found    <= 1'b0;
              end
              srs_pkg::OP_SET_POSITION: begin
                if (chan_ok) begin
                  positions[chan_idx] <= new_position;
                  pending[chan_idx]   <= 1'b1;
                  timers[chan_idx]    <= '0;
                end
              end
              srs_pkg::OP_SET_DURATION: begin
                if (chan_ok) begin
                  durations[chan_idx] <= new_duration;
                end
              end
              default: begin
              end
            endcase
          end
        end
        WALK_S: begin
          timers[idx]    <= step.timer_next;
          positions[idx] <= pos_now;
          if (!found && pend_now) begin
            found        <= 1'b1;
            found_idx    <= idx;
            found_pos    <= pos_now;
            pending[idx] <= 1'b0;
          end else begin
            pending[idx] <= pend_now;
          end
          if (step_cnt == CNT_W'(CHANNELS - 1)) begin
            state <= EMIT_S;
          end else begin
            idx      <= idx_next;
            step_cnt <= step_cnt + CNT_W'(1);
          end
        end
        EMIT_S: begin
          if (!found) begin
            state <= IDLE_S;
          end else if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            m_tdata     <= {3'b000, found_pos, srs_pkg::CHAN_W'(found_idx) + 5'd1};
            last_served <= found_idx;
            state       <= IDLE_S;
          end
        end
        default: begin
          state <= IDLE_S;
        end
      endcase
    end
  end

  // The walk visits every channel exactly once per tick.
  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == WALK_S) |-> (step_cnt <= CNT_W'(CHANNELS - 1)))
    else $error("walk ran past the channel count");

  // The served channel has its pending flag cleared before the result goes out.
  a_found_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT_S && found) |-> !pending[found_idx])
    else $error("served channel still pending");

  // A new result only appears at the end of a tick walk.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == EMIT_S))
    else $error("result raised outside the emit step");

  // The round-robin pointer always names an existing channel.
  a_last_in_range: assert property (@(posedge clk) disable iff (rst)
    (last_served <= LAST_IDX))
    else $error("last served channel out of range");

endmodule

`default_nettype wire

// ===== tb/servo_refresh_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// Servo refresh scheduler testbench
// Sends ticks, set-position, set-duration and unused-code transactions with
// random gaps, and predicts every refresh the block should emit. Each
// transaction taken on the result stream is checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module servo_refresh_scheduler_test;

  localparam int CHANNELS      = srs_pkg::CHANNELS_DEF;
  localparam int RELEASE_TICKS = srs_pkg::RELEASE_TICKS_DEF;
  localparam int RANDOM_ITEMS  = 1500;

  localparam int OP_W     = srs_pkg::OP_W;
  localparam int CHAN_W   = srs_pkg::CHAN_W;
  localparam int POS_W    = srs_pkg::POS_W;
  localparam int DUR_W    = srs_pkg::DUR_W;
  localparam int S_DATA_W = srs_pkg::S_DATA_W;
  localparam int M_DATA_W = srs_pkg::M_DATA_W;

  // One refresh write as the block should emit it.
  typedef struct {
    logic [CHAN_W-1:0] register_number;
    logic [POS_W-1:0]  position_value;
  } refresh_t;

  // Scoreboard: its own copy of the per-channel state and the queue of
  // refresh writes that are still owed by the block.
  class refresh_board;
    logic [DUR_W-1:0] timers[CHANNELS];
    logic [DUR_W-1:0] durations[CHANNELS];
    logic [POS_W-1:0] positions[CHANNELS];
    bit               pending[CHANNELS];
    int unsigned      last_served;
    refresh_t         owed_q[$];
    int unsigned      mismatches;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        timers[c]    = srs_pkg::TIMER_STOPPED;
        durations[c] = DUR_W'(RELEASE_TICKS);
        positions[c] = '0;
        pending[c]   = 1'b1;
      end
      last_served = 0;
      mismatches  = 0;
    endfunction

    // Called for every accepted input transaction.
    function void note_input(srs_pkg::srs_op_t op, logic [CHAN_W-1:0] ch,
                             logic [POS_W-1:0] pos, logic [DUR_W-1:0] dur);
      refresh_t r;
      case (op)
        srs_pkg::OP_SET_POSITION: begin
          if (ch < CHANNELS) begin
            positions[ch] = pos;
            pending[ch]   = 1'b1;
            timers[ch]    = '0;
          end
        end
        srs_pkg::OP_SET_DURATION: begin
          if (ch < CHANNELS) durations[ch] = dur;
        end
        srs_pkg::OP_TICK: begin
          // Advance every running timer; one that passes its duration
          // stops and releases the servo.
          for (int c = 0; c < CHANNELS; c++) begin
            if (timers[c] != srs_pkg::TIMER_STOPPED) begin
              timers[c] = timers[c] + 1'b1;
              if (timers[c] > durations[c]) begin
                timers[c]    = srs_pkg::TIMER_STOPPED;
                positions[c] = '0;
                pending[c]   = 1'b1;
              end
            end
          end
          // Round-robin search from the channel after the last one served.
          if (last_served >= CHANNELS) last_served = 0;
          for (int n = 0; n < CHANNELS; n++) begin
            last_served++;
            if (last_served >= CHANNELS) last_served = 0;
            if (pending[last_served]) break;
          end
          if (pending[last_served]) begin
            pending[last_served] = 1'b0;
            r.register_number    = CHAN_W'(last_served + 1);
            r.position_value     = positions[last_served];
            owed_q.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    // Called for every accepted result transaction.
    function void check_result(logic [M_DATA_W-1:0] data);
      refresh_t want;
      bit       bad;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected refresh, tdata=%h", $realtime, data);
        return;
      end
      want = owed_q.pop_front();
      bad  = (data[4:0] !== want.register_number) ||
             (data[12:5] !== want.position_value) ||
             (data[15:13] !== 3'b000);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: refresh mismatch, expected reg %0d pos %0d, got reg %0d pos %0d pad %b",
                   $realtime, want.register_number, want.position_value,
                   data[4:0], data[12:5], data[15:13]);
      end
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [OP_W-1:0]      s_tuser;   // [1:0] operation
  logic [S_DATA_W-1:0]  s_tdata;   // [4:0] channel, [12:5] new_position,
                                   // [28:13] new_duration, [31:29] zero
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;   // [4:0] register_number,
                                   // [12:5] position_value, [15:13] zero

  refresh_board board;

  // Idle modes: while calm, that side never idles.
  bit          tx_calm;
  bit          rx_calm;
  int unsigned rx_hold;
  int unsigned rx_cycles;

  servo_refresh_scheduler #(
    .CHANNELS              (CHANNELS),
    .DEFAULT_RELEASE_TICKS (RELEASE_TICKS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: a correct run ends far earlier than this.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // Result side. The check uses values sampled before the edge, so it
  // never depends on update order within the time step. The ready line
  // gets exactly one assignment per edge, and only from this block.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    rx_cycles++;
    if (rx_cycles % 500 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_calm) begin
      m_tready <= 1'b1;
    end else begin
      rx_hold = idle_length();
      m_tready <= (rx_hold == 0);
    end
  end

  // Offers one input transaction and returns at the edge that accepts it.
  // Valid is lowered only when a gap follows, so it never gets two
  // assignments in one step.
  task automatic send_item(input srs_pkg::srs_op_t op, input logic [CHAN_W-1:0] ch,
                           input logic [POS_W-1:0] pos, input logic [DUR_W-1:0] dur);
    int unsigned gap;
    gap = tx_calm ? 0 : idle_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, dur, pos, ch};
    do @(posedge clk); while (!s_tready);
    board.note_input(op, ch, pos, dur);
  endtask

  task automatic tick();
    send_item(srs_pkg::OP_TICK, CHAN_W'($urandom), POS_W'($urandom), DUR_W'($urandom));
  endtask

  initial begin
    srs_pkg::srs_op_t  op;
    logic [CHAN_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic [DUR_W-1:0]  dur;
    int unsigned       counted;
    int unsigned       r;
    int unsigned       burst;

    board     = new();
    tx_calm   = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= srs_pkg::OP_TICK;
    s_tdata   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Every channel starts pending, so the first ticks
    // refresh channels 1, 2, 3 with zero positions.
    tick();
    tick();
    tick();
    // Position extremes on the first and last channel.
    send_item(srs_pkg::OP_SET_POSITION, 5'd0, 8'hFF, 16'h0000);
    send_item(srs_pkg::OP_SET_POSITION, CHAN_W'(CHANNELS - 1), 8'h00, 16'hFFFF);
    // Channels out of range are ignored.
    send_item(srs_pkg::OP_SET_POSITION, CHAN_W'(CHANNELS), 8'hA5, 16'h1234);
    send_item(srs_pkg::OP_SET_POSITION, 5'd31, 8'hFF, 16'hFFFF);
    send_item(srs_pkg::OP_SET_DURATION, 5'd31, 8'hFF, 16'h0000);
    // The unused operation code changes nothing.
    send_item(srs_pkg::OP_UNUSED, 5'd0, 8'hFF, 16'hFFFF);
    send_item(srs_pkg::OP_UNUSED, 5'd31, 8'h00, 16'h0000);
    // Shortest duration, a never-release duration, and a one-tick one.
    send_item(srs_pkg::OP_SET_DURATION, 5'd0, 8'h00, 16'h0000);
    send_item(srs_pkg::OP_SET_DURATION, CHAN_W'(CHANNELS - 1), 8'hFF, 16'hFFFF);
    send_item(srs_pkg::OP_SET_DURATION, 5'd5, 8'h3C, 16'h0001);
    send_item(srs_pkg::OP_SET_POSITION, 5'd5, 8'h5A, 16'h0000);
    send_item(srs_pkg::OP_SET_POSITION, 5'd0, 8'h81, 16'h0000);
    repeat (8) tick();

    // Random part: mostly ticks, so pending channels drain and the
    // nothing-pending case comes up; short durations make releases common.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // A run of ticks lets timers expire and the search go full laps.
        burst = $urandom_range(5, 30);
        repeat (burst) tick();
        counted += burst;
        continue;
      end
      if (r < 52)      op = srs_pkg::OP_TICK;
      else if (r < 75) op = srs_pkg::OP_SET_POSITION;
      else if (r < 94) op = srs_pkg::OP_SET_DURATION;
      else             op = srs_pkg::OP_UNUSED;
      ch  = ($urandom_range(0, 9) == 0) ? CHAN_W'($urandom_range(CHANNELS, 31))
                                        : CHAN_W'($urandom_range(0, CHANNELS - 1));
      pos = POS_W'($urandom);
      r   = $urandom_range(0, 99);
      if (r < 55)      dur = DUR_W'($urandom_range(0, 8));
      else if (r < 82) dur = DUR_W'($urandom_range(0, 40));
      else if (r < 94) dur = DUR_W'($urandom);
      else             dur = 16'hFFFF;
      send_item(op, ch, pos, dur);
      if (op == srs_pkg::OP_TICK || (op != srs_pkg::OP_UNUSED && ch < CHANNELS)) counted++;
    end
    s_tvalid <= 1'b0;

    // Drain, then keep the clock running well past a tick walk for stray output.
    while (board.owed() != 0) @(posedge clk);
    repeat (4 * CHANNELS + 20) @(posedge clk);

    if (board.mismatches == 0 && board.owed() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
